// ===== hdl/eurf_pkg.sv =====
// ----------------------------------------------------------------------------
// eurf_pkg - shared types and constants for the encoder unwrap and rate filter
// Field widths, wrap limits, operation codes and the record that leaves the
// unwrap stage for the history store and the output pipeline.
// ----------------------------------------------------------------------------
package eurf_pkg;

    localparam int RAW_W   = 13;
    localparam int RATE_W  = 14;
    localparam int TURN_W  = 16;
    localparam int CAL_W   = 16;
    localparam int COUNT_W = 29;
    localparam int DELTA_W = 30;
    localparam int ANGLE_W = 35;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 128;

    localparam int BUFFER_DEPTH_DEF = 8;

    localparam logic signed [RATE_W-1:0]  WRAP_LIMIT      = 14'sd7500;
    localparam logic signed [RATE_W:0]    COUNTS_PER_TURN = 15'sd8192;
    localparam logic signed [6:0]         Q10_PER_COUNT   = 7'sd45;
    localparam logic signed [TURN_W-1:0]  TURN_MAX        = 16'sh7FFF;
    localparam logic signed [TURN_W-1:0]  TURN_MIN        = 16'sh8000;
    localparam logic [CAL_W-1:0]          CAL_MAX         = 16'hFFFF;

    typedef enum logic {
        OP_SAMPLE    = 1'b0,
        OP_CALIBRATE = 1'b1
    } t_op;

    // One request after the unwrap stage
    typedef struct packed {
        t_op                       op;
        logic signed [COUNT_W-1:0] count;
        logic signed [DELTA_W-1:0] delta;   // continuous count minus bias
        logic signed [RATE_W-1:0]  rate;
        logic signed [TURN_W-1:0]  turns;
        logic [CAL_W-1:0]          cals;
    } t_trk;

endpackage

// ===== hdl/eurf_track.sv =====
// ----------------------------------------------------------------------------
// eurf_track - turn unwrap and calibration state
// Compares each reading with the last one, counts turns with saturation,
// derives the wrap-corrected rate and the continuous count, captures the bias.
// ----------------------------------------------------------------------------
module eurf_track (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_accept,
    input  eurf_pkg::t_op                i_op,
    input  logic [eurf_pkg::RAW_W-1:0]   i_raw,
    output logic                         o_p1_valid,
    output eurf_pkg::t_trk               o_p1
);

    logic [eurf_pkg::RAW_W-1:0]         r_prev;
    logic [eurf_pkg::RAW_W-1:0]         r_bias;
    logic signed [eurf_pkg::TURN_W-1:0] r_turns;
    logic [eurf_pkg::CAL_W-1:0]         r_cals;
    logic                               r_p1_valid;
    eurf_pkg::t_trk                     r_p1;

    logic signed [eurf_pkg::RATE_W-1:0] w_diff;
    logic signed [eurf_pkg::RATE_W:0]   w_diff_x;
    logic signed [eurf_pkg::RATE_W-1:0] w_rate;
    logic signed [eurf_pkg::TURN_W-1:0] n_turns;
    logic [eurf_pkg::CAL_W-1:0]         n_cals;
    eurf_pkg::t_trk                     n_p1;

    assign w_diff   = $signed({1'b0, i_raw}) - $signed({1'b0, r_prev});
    assign w_diff_x = {w_diff[eurf_pkg::RATE_W-1], w_diff};
    assign n_cals   = (r_cals == eurf_pkg::CAL_MAX) ? r_cals : r_cals + 1'b1;

    always_comb begin
        n_turns = r_turns;
        w_rate  = w_diff;
        if (w_diff < -eurf_pkg::WRAP_LIMIT) begin
            if (r_turns != eurf_pkg::TURN_MAX) begin
                n_turns = r_turns + 16'sd1;
            end
            w_rate = eurf_pkg::RATE_W'(w_diff_x + eurf_pkg::COUNTS_PER_TURN);
        end else if (w_diff > eurf_pkg::WRAP_LIMIT) begin
            if (r_turns != eurf_pkg::TURN_MIN) begin
                n_turns = r_turns - 16'sd1;
            end
            w_rate = eurf_pkg::RATE_W'(w_diff_x - eurf_pkg::COUNTS_PER_TURN);
        end
    end

    always_comb begin
        n_p1.op    = i_op;
        n_p1.rate  = w_rate;
        n_p1.delta = $signed({n_turns[eurf_pkg::TURN_W-1], n_turns, i_raw})
                     - $signed({17'd0, r_bias});
        case (i_op)
            eurf_pkg::OP_SAMPLE: begin
                n_p1.count = $signed({n_turns, i_raw});
                n_p1.turns = n_turns;
                n_p1.cals  = r_cals;
            end
            eurf_pkg::OP_CALIBRATE: begin
                n_p1.count = $signed({16'd0, i_raw});
                n_p1.turns = r_turns;
                n_p1.cals  = n_cals;
            end
            default: begin
                n_p1.count = $signed({n_turns, i_raw});
                n_p1.turns = n_turns;
                n_p1.cals  = r_cals;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev     <= '0;
            r_bias     <= '0;
            r_turns    <= '0;
            r_cals     <= '0;
            r_p1_valid <= 1'b0;
        end else begin
            if (i_en) begin
                r_p1_valid <= i_accept;
            end
            if (i_accept) begin
                r_prev <= i_raw;
                if (i_op == eurf_pkg::OP_CALIBRATE) begin
                    r_bias <= i_raw;
                    r_cals <= n_cals;
                end else begin
                    r_turns <= n_turns;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_p1 <= n_p1;
        end
    end

    assign o_p1_valid = r_p1_valid;
    assign o_p1       = r_p1;

endmodule

// ===== hdl/eurf_hist.sv =====
// ----------------------------------------------------------------------------
// eurf_hist - rate history memory and running sum
// Reads the oldest rate when a sample is taken, overwrites it from the unwrap
// register, sums all entries. Entries count as zero until the first wrap.
// ----------------------------------------------------------------------------
module eurf_hist #(
    parameter int    BUFFER_DEPTH = eurf_pkg::BUFFER_DEPTH_DEF,
    localparam int   SumW = eurf_pkg::RATE_W + $clog2(BUFFER_DEPTH)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_accept,
    input  eurf_pkg::t_op          i_op,
    input  logic                   i_p1_valid,
    input  eurf_pkg::t_trk         i_p1,
    output logic signed [SumW-1:0] o_sum
);

    localparam int               IdxW    = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam logic [IdxW-1:0]  LastIdx = IdxW'(BUFFER_DEPTH - 1);

    logic signed [eurf_pkg::RATE_W-1:0] mem [BUFFER_DEPTH];

    logic [IdxW-1:0]                    r_idx;
    logic                               r_full;
    logic [IdxW-1:0]                    r_wr_addr;
    logic                               r_fwd;
    logic signed [eurf_pkg::RATE_W-1:0] r_fwd_rate;
    logic                               r_rd_full;
    logic signed [eurf_pkg::RATE_W-1:0] r_q;
    logic signed [SumW-1:0]             r_sum;

    logic                               w_rd;
    logic                               w_wr;
    logic signed [eurf_pkg::RATE_W-1:0] w_old;
    logic signed [SumW-1:0]             n_sum;

    assign w_rd = i_accept && (i_op == eurf_pkg::OP_SAMPLE);
    assign w_wr = i_en && i_p1_valid && (i_p1.op == eurf_pkg::OP_SAMPLE);

    // forwarded write beats the memory; unwritten entries read as zero
    always_comb begin
        if (r_fwd) begin
            w_old = r_fwd_rate;
        end else if (r_rd_full) begin
            w_old = r_q;
        end else begin
            w_old = '0;
        end
    end

    assign n_sum = r_sum - SumW'(w_old) + SumW'(i_p1.rate);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_full <= 1'b0;
            r_sum  <= '0;
        end else begin
            if (w_rd) begin
                if (r_idx == LastIdx) begin
                    r_idx  <= '0;
                    r_full <= 1'b1;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            if (w_wr) begin
                r_sum <= n_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd) begin
            r_wr_addr  <= r_idx;
            r_fwd      <= w_wr && (r_wr_addr == r_idx);
            r_fwd_rate <= i_p1.rate;
            r_rd_full  <= r_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            mem[r_wr_addr] <= i_p1.rate;
        end
        if (w_rd) begin
            r_q <= mem[r_idx];
        end
    end

    assign o_sum = r_sum;

endmodule

// ===== hdl/eurf_out.sv =====
// ----------------------------------------------------------------------------
// eurf_out - angle scaling, mean division and result register
// Scales continuous count minus bias to Q.10 degrees, divides the running sum
// by the depth via a reciprocal product, holds angle and rates on calibrate.
// ----------------------------------------------------------------------------
module eurf_out #(
    parameter int    BUFFER_DEPTH = eurf_pkg::BUFFER_DEPTH_DEF,
    localparam int   SumW = eurf_pkg::RATE_W + $clog2(BUFFER_DEPTH)
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_p1_valid,
    input  eurf_pkg::t_trk                       i_p1,
    input  logic signed [SumW-1:0]               i_sum,
    output logic                                 o_valid,
    output logic signed [eurf_pkg::COUNT_W-1:0]  o_count,
    output logic signed [eurf_pkg::ANGLE_W-1:0]  o_angle,
    output logic signed [eurf_pkg::RATE_W-1:0]   o_raw_rate,
    output logic signed [eurf_pkg::RATE_W-1:0]   o_filt_rate,
    output logic signed [eurf_pkg::TURN_W-1:0]   o_turns,
    output logic [eurf_pkg::CAL_W-1:0]           o_cals
);

    // floor(n / depth) == (n * Recip) >> Shift for every n below 2**MagW
    localparam int               MagW   = SumW;
    localparam int               Shift  = MagW + $clog2(BUFFER_DEPTH);
    localparam int               RecipW = MagW + 1;
    localparam int               ProdW  = MagW + RecipW;
    localparam logic [RecipW-1:0] Recip =
        RecipW'(((64'd1 << Shift) + 64'(BUFFER_DEPTH) - 64'd1) / 64'(BUFFER_DEPTH));
    localparam int               AProdW = eurf_pkg::DELTA_W + 7;

    logic                               r_p2_valid;
    eurf_pkg::t_trk                     r_p2;
    logic signed [eurf_pkg::ANGLE_W-1:0] r_p2_angle;
    logic                               r_p3_valid;
    eurf_pkg::t_trk                     r_p3;
    logic signed [eurf_pkg::ANGLE_W-1:0] r_p3_angle;
    logic [eurf_pkg::RATE_W-1:0]        r_p3_q;
    logic                               r_p3_neg;

    logic                               r_out_valid;
    logic signed [eurf_pkg::COUNT_W-1:0] r_count;
    logic signed [eurf_pkg::ANGLE_W-1:0] r_angle;
    logic signed [eurf_pkg::RATE_W-1:0] r_raw_rate;
    logic signed [eurf_pkg::RATE_W-1:0] r_filt_rate;
    logic signed [eurf_pkg::TURN_W-1:0] r_turns;
    logic [eurf_pkg::CAL_W-1:0]         r_cals;

    logic signed [AProdW-1:0]           w_angle_prod;
    logic                               w_neg;
    logic [MagW-1:0]                    w_mag;
    logic [ProdW-1:0]                   w_prod;
    logic signed [eurf_pkg::RATE_W-1:0] w_filt;

    assign w_angle_prod = i_p1.delta * eurf_pkg::Q10_PER_COUNT;

    // divide the magnitude so the mean truncates toward zero
    assign w_neg  = i_sum[SumW-1];
    assign w_mag  = w_neg ? MagW'(-i_sum) : MagW'(i_sum);
    assign w_prod = ProdW'(w_mag) * ProdW'(Recip);

    assign w_filt = r_p3_neg ? -$signed(r_p3_q) : $signed(r_p3_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_valid  <= 1'b0;
            r_p3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_angle     <= '0;
            r_raw_rate  <= '0;
            r_filt_rate <= '0;
        end else if (i_en) begin
            r_p2_valid  <= i_p1_valid;
            r_p3_valid  <= r_p2_valid;
            r_out_valid <= r_p3_valid;
            // calibrate keeps the last angle and rates
            if (r_p3_valid && (r_p3.op == eurf_pkg::OP_SAMPLE)) begin
                r_angle     <= r_p3_angle;
                r_raw_rate  <= r_p3.rate;
                r_filt_rate <= w_filt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p2       <= i_p1;
            r_p2_angle <= w_angle_prod[eurf_pkg::ANGLE_W-1:0];
            r_p3       <= r_p2;
            r_p3_angle <= r_p2_angle;
            r_p3_q     <= w_prod[Shift +: eurf_pkg::RATE_W];
            r_p3_neg   <= w_neg;
            if (r_p3_valid) begin
                r_count <= r_p3.count;
                r_turns <= r_p3.turns;
                r_cals  <= r_p3.cals;
            end
        end
    end

    assign o_valid     = r_out_valid;
    assign o_count     = r_count;
    assign o_angle     = r_angle;
    assign o_raw_rate  = r_raw_rate;
    assign o_filt_rate = r_filt_rate;
    assign o_turns     = r_turns;
    assign o_cals      = r_cals;

endmodule

// ===== hdl/encoder_unwrap_rate_filter_core.sv =====
// ----------------------------------------------------------------------------
// encoder_unwrap_rate_filter_core - multiturn encoder unwrap with rate mean
// Top level: stream ports, pipeline enable, unwrap, history and result stages.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle while the output does not stall;
// a request passes the unwrap register, the p2 and p3 registers and the result
// register. The rate history memory is read once when a sample enters and
// written once as it leaves the unwrap register, with the running sum updated in
// that same cycle and the pending write forwarded to a read of the same entry.
// The whole pipeline stalls while a result waits at the output, so ready on the
// input follows ready on the output. The history needs no clearing pass after
// reset: entries are taken as zero until the write pointer first wraps. Results
// come out in request order, one per request, calibrate requests included.
module encoder_unwrap_rate_filter_core #(
    parameter int BUFFER_DEPTH = eurf_pkg::BUFFER_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [eurf_pkg::S_TDATA_W-1:0]    i_s_tdata,   // [12:0] angle_raw, [15:13] zero
    input  logic                              i_s_tuser,   // [0] operation
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // [28:0] continuous_count, [63:29] angle_q10, [77:64] raw_rate,
    // [91:78] filtered_rate, [107:92] turn_count, [123:108] calibration_count,
    // [127:124] zero
    output logic [eurf_pkg::M_TDATA_W-1:0]    o_m_tdata
);

    localparam int SumW = eurf_pkg::RATE_W + $clog2(BUFFER_DEPTH);

    logic                                w_en;
    logic                                w_accept;
    eurf_pkg::t_op                       w_op;
    logic                                w_p1_valid;
    eurf_pkg::t_trk                      w_p1;
    logic signed [SumW-1:0]              w_sum;
    logic signed [eurf_pkg::COUNT_W-1:0] w_count;
    logic signed [eurf_pkg::ANGLE_W-1:0] w_angle;
    logic signed [eurf_pkg::RATE_W-1:0]  w_raw_rate;
    logic signed [eurf_pkg::RATE_W-1:0]  w_filt_rate;
    logic signed [eurf_pkg::TURN_W-1:0]  w_turns;
    logic [eurf_pkg::CAL_W-1:0]          w_cals;

    // advance whenever the result register is empty or being drained
    assign w_en       = !o_m_tvalid || i_m_tready;
    assign w_accept   = i_s_tvalid && w_en;
    assign o_s_tready = w_en;
    assign w_op       = eurf_pkg::t_op'(i_s_tuser);

    eurf_track u_track (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_accept   (w_accept),
        .i_op       (w_op),
        .i_raw      (i_s_tdata[eurf_pkg::RAW_W-1:0]),
        .o_p1_valid (w_p1_valid),
        .o_p1       (w_p1)
    );

    eurf_hist #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_hist (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_accept   (w_accept),
        .i_op       (w_op),
        .i_p1_valid (w_p1_valid),
        .i_p1       (w_p1),
        .o_sum      (w_sum)
    );

    eurf_out #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_p1_valid  (w_p1_valid),
        .i_p1        (w_p1),
        .i_sum       (w_sum),
        .o_valid     (o_m_tvalid),
        .o_count     (w_count),
        .o_angle     (w_angle),
        .o_raw_rate  (w_raw_rate),
        .o_filt_rate (w_filt_rate),
        .o_turns     (w_turns),
        .o_cals      (w_cals)
    );

    assign o_m_tdata = {4'd0, w_cals, w_turns, w_filt_rate, w_raw_rate, w_angle, w_count};

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench - encoder unwrap and rate filter core
// Streams encoder samples and calibrate requests into the core and predicts
// each result in step with every accepted request. The checks cover turn
// counting in both directions, calibration counting, the Q.10 angle and the
// mean over the rate history. Both stream sides idle at random, with stretches
// at full rate, one long output hold-off and one full drain of the pipeline.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     HIST_DEPTH   = eurf_pkg::BUFFER_DEPTH_DEF;
    localparam longint Q10_PER_TURN = 368640;
    localparam int     WALK_ITEMS   = 1090;
    localparam int     SAT_PAIRS    = 10;
    localparam int     MAX_REPORTS  = 10;

    // Result fields, continuous_count in the lowest bits
    typedef struct packed {
        logic [eurf_pkg::CAL_W-1:0]          cals;
        logic signed [eurf_pkg::TURN_W-1:0]  turns;
        logic signed [eurf_pkg::RATE_W-1:0]  filt;
        logic signed [eurf_pkg::RATE_W-1:0]  rate;
        logic signed [eurf_pkg::ANGLE_W-1:0] angle;
        logic signed [eurf_pkg::COUNT_W-1:0] count;
    } t_report;

    typedef struct {
        eurf_pkg::t_op              op;
        logic [eurf_pkg::RAW_W-1:0] raw;
        int                         gap;
        bit                         drain_first;
    } t_reading;

    localparam int    FIELD_LO [6] = '{0, 29, 64, 78, 92, 108};
    localparam int    FIELD_W  [6] = '{29, 35, 14, 14, 16, 16};
    localparam string FIELD_NAME [6] = '{"continuous_count", "angle_q10", "raw_rate",
                                         "filtered_rate", "turn_count", "calibration_count"};

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           s_valid = 1'b0;
    logic                           o_s_tready;
    logic [eurf_pkg::S_TDATA_W-1:0] s_data = '0;   // [12:0] angle_raw, [15:13] zero
    logic                           s_user = 1'b0; // [0] operation
    logic                           o_m_tvalid;
    logic                           m_ready = 1'b0;
    logic [eurf_pkg::M_TDATA_W-1:0] o_m_tdata;     // result fields as in t_report, [127:124] zero

    encoder_unwrap_rate_filter_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_valid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_data),
        .i_s_tuser  (s_user),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_ready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predicted unwrap and filter state
    logic [eurf_pkg::RAW_W-1:0]          last_pos;
    logic [eurf_pkg::RAW_W-1:0]          zero_pos;
    logic signed [eurf_pkg::TURN_W-1:0]  turn_cnt;
    logic signed [eurf_pkg::RATE_W-1:0]  rate_hist [HIST_DEPTH];
    int                                  hist_ptr;
    int                                  rate_total;
    logic signed [eurf_pkg::ANGLE_W-1:0] last_angle;
    logic signed [eurf_pkg::RATE_W-1:0]  last_rate;
    logic signed [eurf_pkg::RATE_W-1:0]  last_mean;
    logic [eurf_pkg::CAL_W-1:0]          cal_cnt;

    t_reading reading_queue[$];
    t_report  pending_reports[$];

    bit       req_taken;
    bit       rsp_taken;
    bit       armed;
    bit       long_hold;
    t_reading staged;
    int       gap_left;
    int       rx_wait;
    int       accepted_count;
    int       results_seen;
    int       n_varied = 0;
    int       mismatches;
    logic [eurf_pkg::RAW_W-1:0] walk_pos;

    initial begin
        last_pos   = '0;
        zero_pos   = '0;
        turn_cnt   = '0;
        hist_ptr   = 0;
        rate_total = 0;
        last_angle = '0;
        last_rate  = '0;
        last_mean  = '0;
        cal_cnt    = '0;
        foreach (rate_hist[k]) rate_hist[k] = '0;
    end

    function automatic t_report track_reading(eurf_pkg::t_op op,
                                              logic [eurf_pkg::RAW_W-1:0] raw);
        int      diff;
        int      rate;
        t_report r;
        if (op == eurf_pkg::OP_CALIBRATE) begin
            zero_pos = raw;
            last_pos = raw;
            if (cal_cnt != eurf_pkg::CAL_MAX) cal_cnt++;
            r.count = eurf_pkg::COUNT_W'(raw);
        end else begin
            diff = int'(raw) - int'(last_pos);
            if (diff < -int'(eurf_pkg::WRAP_LIMIT)) begin
                if (turn_cnt != eurf_pkg::TURN_MAX) turn_cnt++;
                rate = diff + int'(eurf_pkg::COUNTS_PER_TURN);
            end else if (diff > int'(eurf_pkg::WRAP_LIMIT)) begin
                if (turn_cnt != eurf_pkg::TURN_MIN) turn_cnt--;
                rate = diff - int'(eurf_pkg::COUNTS_PER_TURN);
            end else begin
                rate = diff;
            end
            last_pos   = raw;
            r.count    = eurf_pkg::COUNT_W'(int'(raw)
                                            + int'(turn_cnt) * int'(eurf_pkg::COUNTS_PER_TURN));
            last_angle = eurf_pkg::ANGLE_W'((longint'(raw) - longint'(zero_pos))
                                            * longint'(eurf_pkg::Q10_PER_COUNT)
                                            + longint'(turn_cnt) * Q10_PER_TURN);
            last_rate  = eurf_pkg::RATE_W'(rate);
            rate_total = rate_total - int'(rate_hist[hist_ptr]) + rate;
            rate_hist[hist_ptr] = eurf_pkg::RATE_W'(rate);
            hist_ptr   = (hist_ptr + 1) % HIST_DEPTH;
            last_mean  = eurf_pkg::RATE_W'(rate_total / HIST_DEPTH);
        end
        r.angle = last_angle;
        r.rate  = last_rate;
        r.filt  = last_mean;
        r.turns = turn_cnt;
        r.cals  = cal_cnt;
        return r;
    endfunction

    task automatic queue_reading(eurf_pkg::t_op op, logic [eurf_pkg::RAW_W-1:0] raw, int gap,
                                 bit drain_first);
        reading_queue.push_back('{op, raw, gap, drain_first});
        walk_pos = raw;
    endtask

    // Sender: present the next request after its gap, hold until taken
    always @(negedge i_clk) begin
        logic v;
        v = s_valid;
        if (i_rst_n && (!s_valid || req_taken)) begin
            v = 1'b0;
            if (!armed && reading_queue.size() > 0) begin
                staged   = reading_queue.pop_front();
                gap_left = staged.gap;
                armed    = 1'b1;
            end
            if (armed) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (!staged.drain_first || pending_reports.size() == 0) begin
                    s_data <= eurf_pkg::S_TDATA_W'(staged.raw);
                    s_user <= staged.op;
                    v      = 1'b1;
                    armed  = 1'b0;
                end
            end
        end
        s_valid <= v;
    end

    // Receiver: draw a stall after each result, none in the steady stretches
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (rsp_taken) begin
                if (results_seen >= n_varied || (results_seen / 64) % 4 == 0)
                    rx_wait = 0;
                else
                    rx_wait = $urandom_range(0, 9);
            end
            if (long_hold) begin
                m_ready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Predict on every accepted request, check every accepted result
    always @(posedge i_clk) begin
        t_report want;
        t_report got;
        logic [63:0] fw;
        logic [63:0] fg;
        req_taken = i_rst_n && s_valid && o_s_tready;
        rsp_taken = i_rst_n && o_m_tvalid && m_ready;
        if (req_taken) begin
            pending_reports.push_back(track_reading(eurf_pkg::t_op'(s_user),
                                                    s_data[eurf_pkg::RAW_W-1:0]));
            accepted_count++;
        end
        if (rsp_taken) begin
            got = t_report'(o_m_tdata[$bits(t_report)-1:0]);
            if (pending_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("result %0d arrived with nothing expected: %h",
                             results_seen, o_m_tdata);
            end else begin
                want = pending_reports.pop_front();
                for (int f = 0; f < 6; f++) begin
                    fw = 64'(want >> FIELD_LO[f]) & ((64'd1 << FIELD_W[f]) - 1);
                    fg = 64'(got >> FIELD_LO[f]) & ((64'd1 << FIELD_W[f]) - 1);
                    if (fw != fg) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("result %0d %s: expected %h, got %h",
                                     results_seen, FIELD_NAME[f], fw, fg);
                    end
                end
            end
            results_seen++;
        end
    end

    // Hold the output off long enough to back the pipeline up into the input
    initial begin
        wait (accepted_count >= 400);
        long_hold = 1'b1;
        repeat (300) @(negedge i_clk);
        long_hold = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        int            pick;
        int            step;
        int            gap;
        eurf_pkg::t_op op;
        walk_pos = '0;

        // Wrap edges, exact limits, calibrate extremes, filter start-up
        queue_reading(eurf_pkg::OP_SAMPLE, 13'd0, 0, 0);
        queue_reading(eurf_pkg::OP_SAMPLE, 13'd8191, 1, 0);
        queue_reading(eurf_pkg::OP_SAMPLE, 13'd691, 0, 0);
        queue_reading(eurf_pkg::OP_SAMPLE, 13'd8191, 3, 0);
        queue_reading(eurf_pkg::OP_SAMPLE, 13'd690, 0, 0);
        queue_reading(eurf_pkg::OP_SAMPLE, 13'd8191, 0, 0);
        queue_reading(eurf_pkg::OP_CALIBRATE, 13'd4096, 2, 0);
        queue_reading(eurf_pkg::OP_SAMPLE, 13'd4096, 0, 0);
        queue_reading(eurf_pkg::OP_CALIBRATE, 13'd0, 0, 0);
        queue_reading(eurf_pkg::OP_SAMPLE, 13'd7500, 0, 0);
        queue_reading(eurf_pkg::OP_SAMPLE, 13'd0, 5, 0);
        queue_reading(eurf_pkg::OP_SAMPLE, 13'd7501, 0, 0);
        queue_reading(eurf_pkg::OP_CALIBRATE, 13'd8191, 0, 0);
        queue_reading(eurf_pkg::OP_SAMPLE, 13'd0, 0, 0);
        queue_reading(eurf_pkg::OP_SAMPLE, 13'd8191, 9, 0);
        queue_reading(eurf_pkg::OP_CALIBRATE, 13'h1555, 0, 0);
        queue_reading(eurf_pkg::OP_SAMPLE, 13'h0AAA, 0, 0);
        queue_reading(eurf_pkg::OP_SAMPLE, 13'd1, 0, 0);
        queue_reading(eurf_pkg::OP_SAMPLE, 13'd3, 0, 0);
        queue_reading(eurf_pkg::OP_SAMPLE, 13'd8190, 0, 0);

        // Random walk over the dial: slow moves, fast moves near the wrap limit
        for (int i = 0; i < WALK_ITEMS; i++) begin
            gap = ((i / 80) % 3 == 0) ? 0 : $urandom_range(0, 9);
            op  = eurf_pkg::OP_SAMPLE;
            pick = $urandom_range(0, 4);
            if ($urandom_range(0, 99) < 6) begin
                op   = eurf_pkg::OP_CALIBRATE;
                step = $urandom_range(0, 8191) - int'(walk_pos);
            end else if (pick == 0) begin
                step = $urandom_range(0, 128) - 64;
            end else if (pick == 1) begin
                step = $urandom_range(0, 4000) - 2000;
            end else if (pick == 2) begin
                step = $urandom_range(7400, 7600);
                if ($urandom_range(0, 1)) step = -step;
            end else if (pick == 3) begin
                step = $urandom_range(0, 8191) - int'(walk_pos);
            end else begin
                step = $urandom_range(8100, 8191);
                if ($urandom_range(0, 1)) step = -step;
            end
            queue_reading(op, eurf_pkg::RAW_W'(int'(walk_pos) + step), gap, i == 700);
        end
        n_varied = reading_queue.size();

        // Step the turn count up, then down, with a calibrate before each sample
        for (int i = 0; i < SAT_PAIRS; i++) begin
            queue_reading(eurf_pkg::OP_CALIBRATE, 13'd8191, 0, 0);
            queue_reading(eurf_pkg::OP_SAMPLE, 13'd0, 0, 0);
        end
        for (int i = 0; i < SAT_PAIRS; i++) begin
            queue_reading(eurf_pkg::OP_CALIBRATE, 13'd0, 0, 0);
            queue_reading(eurf_pkg::OP_SAMPLE, 13'd8191, 0, 0);
        end

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (reading_queue.size() > 0 || armed || s_valid) @(negedge i_clk);
        while (pending_reports.size() > 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);

        if (mismatches == 0 && pending_reports.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
